@@ rtl/core/rbb_pkg.sv @@
// Shared types, constants and the reciprocal lookup for the 3x3 box blur.
`default_nettype none

package rbb_pkg;

    localparam int MaxWidth   = 1024;
    localparam int MaxHeight  = 4096;
    localparam int ColW       = $clog2(MaxWidth);
    localparam int WidthRegW  = 11;
    localparam int HeightRegW = 13;
    localparam int InRowW     = 13;
    localparam int OutRowW    = 12;
    localparam int SumW       = 12;
    localparam int CntW       = 4;
    localparam int FracW      = 16;
    localparam int RecipW     = FracW + 1;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 13;

    localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = 2'd1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    // Per-item control decided at acceptance. Bit 0 of row_ok is the upper row,
    // bit 0 of col_ok the left column.
    typedef struct packed {
        logic            emit;
        logic            last;
        logic [2:0]      row_ok;
        logic [2:0]      col_ok;
        logic [CntW-1:0] cnt;
    } t_ctrl;

    typedef struct packed {
        logic            vld;
        logic            last;
        logic [CntW-1:0] cnt;
        logic [SumW-1:0] sum_red;
        logic [SumW-1:0] sum_green;
        logic [SumW-1:0] sum_blue;
    } t_sums;

    // Fixed-point reciprocal, scaled by 2^FracW. The divisors 3, 6 and 9 are rounded up;
    // the error stays small enough for exact quotients over the whole sum range.
    function automatic logic [RecipW-1:0] recip(input logic [CntW-1:0] cnt);
        logic [RecipW-1:0] m;
        case (cnt)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd6:    m = 17'd10923;
            4'd9:    m = 17'd7282;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/rbb_ctrl.sv @@
// Frame registers, input and output position counters, and per-item control.
`default_nettype none

module rbb_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [rbb_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [rbb_pkg::CfgDataW-1:0]  i_cfg_data,
    input  wire logic                          i_accept,
    input  wire logic                          i_drain,
    output      logic                          o_process,
    output      logic [rbb_pkg::ColW-1:0]      o_col,
    output      rbb_pkg::t_ctrl                o_ctrl
);
    import rbb_pkg::*;

    logic [WidthRegW-1:0]  r_frame_width,  n_frame_width;
    logic [HeightRegW-1:0] r_frame_height, n_frame_height;
    logic [ColW-1:0]       r_in_col,  n_in_col;
    logic [InRowW-1:0]     r_in_row,  n_in_row;
    logic [ColW-1:0]       r_out_col, n_out_col;
    logic [OutRowW-1:0]    r_out_row, n_out_row;

    logic [WidthRegW-1:0]  w_eff;
    logic [HeightRegW-1:0] h_eff;
    logic [WidthRegW-1:0]  in_col_inc;
    logic [WidthRegW-1:0]  out_col_inc;
    logic [HeightRegW-1:0] out_row_inc;
    logic                  col_wrap;
    logic                  emit;
    logic                  last;
    logic [2:0]            row_ok;
    logic [2:0]            col_ok;
    logic [1:0]            n_rows;
    logic [1:0]            n_cols;
    logic                  cfg_hit;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WidthRegW'(1);
        end else if (r_frame_width > WidthRegW'(MaxWidth)) begin
            w_eff = WidthRegW'(MaxWidth);
        end else begin
            w_eff = r_frame_width;
        end
        if (r_frame_height == '0) begin
            h_eff = HeightRegW'(1);
        end else if (r_frame_height > HeightRegW'(MaxHeight)) begin
            h_eff = HeightRegW'(MaxHeight);
        end else begin
            h_eff = r_frame_height;
        end
    end

    always_comb begin
        in_col_inc  = {1'b0, r_in_col} + WidthRegW'(1);
        out_col_inc = {1'b0, r_out_col} + WidthRegW'(1);
        out_row_inc = {1'b0, r_out_row} + HeightRegW'(1);
        col_wrap    = (in_col_inc >= w_eff);

        // Pixels are taken only inside the frame, drain steps only after it.
        o_process = i_drain ? (r_in_row >= h_eff) : (r_in_row < h_eff);
        emit = (r_in_row >= InRowW'(2)) || ((r_in_row == InRowW'(1)) && (r_in_col != '0));
        last = emit && (out_row_inc >= h_eff) && (out_col_inc >= w_eff);

        row_ok = {out_row_inc < h_eff, 1'b1, r_out_row != '0};
        col_ok = {out_col_inc < w_eff, 1'b1, r_out_col != '0};
        n_rows = 2'd1 + {1'b0, row_ok[0]} + {1'b0, row_ok[2]};
        n_cols = 2'd1 + {1'b0, col_ok[0]} + {1'b0, col_ok[2]};

        o_col         = r_in_col;
        o_ctrl.emit   = emit;
        o_ctrl.last   = last;
        o_ctrl.row_ok = row_ok;
        o_ctrl.col_ok = col_ok;
        o_ctrl.cnt    = {2'b00, n_rows} * {2'b00, n_cols};
    end

    always_comb begin
        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        n_in_col       = r_in_col;
        n_in_row       = r_in_row;
        n_out_col      = r_out_col;
        n_out_row      = r_out_row;
        cfg_hit        = i_cfg_valid &&
                         ((i_cfg_index == CFG_FRAME_WIDTH) || (i_cfg_index == CFG_FRAME_HEIGHT));

        if (cfg_hit) begin
            if (i_cfg_index == CFG_FRAME_WIDTH) begin
                n_frame_width = i_cfg_data[WidthRegW-1:0];
            end else begin
                n_frame_height = i_cfg_data;
            end
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (i_accept && o_process) begin
            if (last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                n_in_col = col_wrap ? '0 : in_col_inc[ColW-1:0];
                n_in_row = r_in_row + InRowW'(col_wrap);
                if (emit) begin
                    if (out_col_inc >= w_eff) begin
                        n_out_col = '0;
                        n_out_row = out_row_inc[OutRowW-1:0];
                    end else begin
                        n_out_col = out_col_inc[ColW-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WidthRegW'(1024);
            r_frame_height <= HeightRegW'(768);
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
        end else begin
            r_frame_width  <= n_frame_width;
            r_frame_height <= n_frame_height;
            r_in_col       <= n_in_col;
            r_in_row       <= n_in_row;
            r_out_col      <= n_out_col;
            r_out_row      <= n_out_row;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rbb_line_store.sv @@
// Two line stores held as one memory of {middle, upper} pairs, with write bypass.
`default_nettype none

module rbb_line_store (
    input  wire logic                      i_clk,
    input  wire logic                      i_rd_en,
    input  wire logic [rbb_pkg::ColW-1:0]  i_rd_addr,
    input  wire logic                      i_wr_en,
    input  wire logic [rbb_pkg::ColW-1:0]  i_wr_addr,
    input  wire rbb_pkg::t_pix             i_wr_pix,
    output      rbb_pkg::t_pix             o_up,
    output      rbb_pkg::t_pix             o_mid
);
    import rbb_pkg::*;

    typedef struct packed {
        t_pix mid;
        t_pix up;
    } t_pair;

    t_pair mem [MaxWidth];
    t_pair r_q;
    t_pair wr_pair;

    // The middle row moves up and the new pixel becomes the middle row.
    always_comb begin
        wr_pair.mid = i_wr_pix;
        wr_pair.up  = r_q.mid;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= wr_pair;
        end
    end

    // With a one-pixel row the next read hits the entry being written.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_q <= wr_pair;
            end else begin
                r_q <= mem[i_rd_addr];
            end
        end
    end

    assign o_up  = r_q.up;
    assign o_mid = r_q.mid;

endmodule

`default_nettype wire

@@ rtl/core/rbb_window.sv @@
// 3x3 window registers and the masked per-channel neighbor sums.
`default_nettype none

module rbb_window (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire logic            i_vld,
    input  wire rbb_pkg::t_pix   i_up,
    input  wire rbb_pkg::t_pix   i_mid,
    input  wire rbb_pkg::t_pix   i_pix,
    input  wire rbb_pkg::t_ctrl  i_ctrl,
    output      rbb_pkg::t_sums  o_sums
);
    import rbb_pkg::*;

    t_pix  r_win [3][3];
    t_pix  cur   [3][3];
    t_pix  new_col [3];
    t_sums r_sums;
    t_sums n_sums;

    always_comb begin
        new_col[0] = i_up;
        new_col[1] = i_mid;
        new_col[2] = i_pix;
        for (int i = 0; i < 3; i++) begin
            cur[i][0] = r_win[i][1];
            cur[i][1] = r_win[i][2];
            cur[i][2] = new_col[i];
        end
    end

    always_comb begin
        n_sums.vld       = i_vld && i_ctrl.emit;
        n_sums.last      = i_ctrl.last;
        n_sums.cnt       = i_ctrl.cnt;
        n_sums.sum_red   = '0;
        n_sums.sum_green = '0;
        n_sums.sum_blue  = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (i_ctrl.row_ok[i] && i_ctrl.col_ok[j]) begin
                    n_sums.sum_red   = n_sums.sum_red   + {4'd0, cur[i][j].red};
                    n_sums.sum_green = n_sums.sum_green + {4'd0, cur[i][j].green};
                    n_sums.sum_blue  = n_sums.sum_blue  + {4'd0, cur[i][j].blue};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_adv && i_vld) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= cur[i][j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sums.vld <= 1'b0;
        end else if (i_adv) begin
            r_sums.vld <= n_sums.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sums.last      <= n_sums.last;
            r_sums.cnt       <= n_sums.cnt;
            r_sums.sum_red   <= n_sums.sum_red;
            r_sums.sum_green <= n_sums.sum_green;
            r_sums.sum_blue  <= n_sums.sum_blue;
        end
    end

    assign o_sums = r_sums;

endmodule

`default_nettype wire

@@ rtl/core/rbb_avg.sv @@
// Rounded division of the sums by the neighbor count, into the result register.
`default_nettype none

module rbb_avg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire rbb_pkg::t_sums  i_sums,
    output      logic            o_vld,
    output      rbb_pkg::t_pix   o_pix,
    output      logic            o_last
);
    import rbb_pkg::*;

    localparam int ProdW = SumW + RecipW;

    logic [SumW-1:0]   half;
    logic [SumW-1:0]   x_red, x_green, x_blue;
    logic [RecipW-1:0] m;
    logic [ProdW-1:0]  p_red, p_green, p_blue;
    logic              r_vld;
    t_pix              r_pix;
    logic              r_last;

    // Round half up: (sum + cnt/2) / cnt, the quotient taken as a product with
    // the scaled reciprocal.
    always_comb begin
        half    = {{(SumW-CntW+1){1'b0}}, i_sums.cnt[CntW-1:1]};
        x_red   = i_sums.sum_red   + half;
        x_green = i_sums.sum_green + half;
        x_blue  = i_sums.sum_blue  + half;
        m       = recip(i_sums.cnt);
        p_red   = {{RecipW{1'b0}}, x_red}   * {{SumW{1'b0}}, m};
        p_green = {{RecipW{1'b0}}, x_green} * {{SumW{1'b0}}, m};
        p_blue  = {{RecipW{1'b0}}, x_blue}  * {{SumW{1'b0}}, m};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_sums.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pix.red   <= p_red[FracW+7:FracW];
            r_pix.green <= p_green[FracW+7:FracW];
            r_pix.blue  <= p_blue[FracW+7:FracW];
            r_last      <= i_sums.last;
        end
    end

    assign o_vld  = r_vld;
    assign o_pix  = r_pix;
    assign o_last = r_last;

endmodule

`default_nettype wire

@@ rtl/core/rgb_box_blur_3x3.sv @@
// Top level of the RGB 3x3 box blur: stream ports, input stage and pipeline glue.
//
//  Channel   | Direction | Payload                             | Transfer
//  ----------+-----------+-------------------------------------+------------------------
//  s_axis    | in        | tdata: red, green, blue; tuser: cmd | tvalid & tready
//  m_axis    | out       | tdata: red, green, blue; tlast      | tvalid & tready
//  cfg       | in        | index 0 width, index 1 height       | i_cfg_valid & o_cfg_ready
//
// One transaction per clock is taken while the result register is free or being read.
// The transaction that completes a window moves through the input stage, the sum register
// and the result register; it comes frame_width + 1 items after the result's own pixel.
// The line-store memory (one read and one write port) and the window advance together
// with the result register; a stalled output holds the whole pipeline.
// Reset is synchronous; the line stores are not cleared and need no clearing pass.
`default_nettype none

module rgb_box_blur_3x3 (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output      logic                          s_axis_tready,
    input  wire logic [23:0]                   s_axis_tdata,  // in_red, in_green, in_blue
    input  wire logic                          s_axis_tuser,  // command
    output      logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output      logic [23:0]                   m_axis_tdata,  // out_red, out_green, out_blue
    output      logic                          m_axis_tlast,
    input  wire logic                          i_cfg_valid,
    output      logic                          o_cfg_ready,
    input  wire logic [rbb_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [rbb_pkg::CfgDataW-1:0]  i_cfg_data
);
    import rbb_pkg::*;

    logic            adv;
    logic            accept;
    logic            process;
    logic [ColW-1:0] col;
    t_ctrl           ctrl;
    t_pix            in_pix;

    logic            r_s1_vld;
    t_pix            r_s1_pix;
    logic [ColW-1:0] r_s1_col;
    t_ctrl           r_s1_ctrl;

    t_pix            up;
    t_pix            mid;
    t_sums           sums;
    logic            out_vld;
    t_pix            out_pix;
    logic            out_last;

    assign adv           = !out_vld || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;
    assign o_cfg_ready   = 1'b1;

    assign in_pix.red   = s_axis_tdata[7:0];
    assign in_pix.green = s_axis_tdata[15:8];
    assign in_pix.blue  = s_axis_tdata[23:16];

    rbb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_drain     (s_axis_tuser),
        .o_process   (process),
        .o_col       (col),
        .o_ctrl      (ctrl)
    );

    // Drain steps push a zero pixel through the stores and the window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= accept && process;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && accept && process) begin
            r_s1_pix  <= s_axis_tuser ? '0 : in_pix;
            r_s1_col  <= col;
            r_s1_ctrl <= ctrl;
        end
    end

    rbb_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (accept && process),
        .i_rd_addr (col),
        .i_wr_en   (adv && r_s1_vld),
        .i_wr_addr (r_s1_col),
        .i_wr_pix  (r_s1_pix),
        .o_up      (up),
        .o_mid     (mid)
    );

    rbb_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (r_s1_vld),
        .i_up    (up),
        .i_mid   (mid),
        .i_pix   (r_s1_pix),
        .i_ctrl  (r_s1_ctrl),
        .o_sums  (sums)
    );

    rbb_avg u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_sums  (sums),
        .o_vld   (out_vld),
        .o_pix   (out_pix),
        .o_last  (out_last)
    );

    assign m_axis_tvalid = out_vld;
    assign m_axis_tdata  = {out_pix.blue, out_pix.green, out_pix.red};
    assign m_axis_tlast  = out_last;

endmodule

`default_nettype wire
